// ===== sv/thbh_pkg.sv =====
// Shared types, constants and register indexes of the threshold-bin histogram.
package thbh_pkg;

  // Field widths
  localparam int SampleW  = 14;
  localparam int ThrW     = 14;
  localparam int CountW   = 16;
  localparam int BinIdxW  = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  // Wide enough for a bound of up to 65536
  localparam int BoundW   = 17;

  // Default geometry
  localparam int DefBinCount    = 6;
  localparam int DefSampleScale = 10000;

  // Queue depths
  localparam int BinQueueDepth = 4;
  localparam int ResQueueDepth = 8;

  // Configuration registers
  localparam int NumThr = 5;
  localparam logic [CfgIdxW-1:0] CfgIdxSamples = 3'd5;

  localparam logic [ThrW-1:0] ThrReset [NumThr] = '{
    14'd3500, 14'd6700, 14'd8000, 14'd9000, 14'd9550
  };
  localparam logic [CountW-1:0] SamplesReset = 16'd2500;
  localparam logic [CountW-1:0] CountMax     = 16'hFFFF;

  typedef logic [NumThr-1:0][ThrW-1:0] thr_set_t;

  // One result of a closed round
  typedef struct packed {
    logic [BinIdxW-1:0] bin_index;
    logic [CountW-1:0]  round_count;
    logic [CountW-1:0]  lowest_count;
    logic [CountW-1:0]  highest_count;
    logic               last;
  } result_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } back_state_e;

endpackage

// ===== sv/threshold_bin_histogram_minmax_core.sv =====
// Top level of the threshold-bin histogram with per-bin running min and max.
//
// Samples enter through a queue-style port: a transfer happens on a clock edge
// with push high and full low. Each sample is classified into a bin by the
// five threshold registers and counted. Once samples_per_round samples are in,
// the round closes and BIN_COUNT results come out, bin one first, the final
// one flagged by last_o. A result is shown while empty is low and leaves on an
// edge with pop high. Configuration writes take effect on the edge where
// cfg_we_i is high; write only while the block is idle.
// Throughput: one sample per cycle while a round runs. Closing a round holds
// the back end in its result drain (one result per cycle from the min/max
// sequencer while the result queue is not full); a four-entry bin queue
// absorbs samples meanwhile, after which full rises until the drain ends.
// The first result of a round becomes visible once the closing sample has left
// the bin queue and the drain sequencer has written that result to the result queue.
// A stalled receiver fills the eight-entry result queue and then halts the
// drain sequencer; samples back up into the bin queue. Nothing is dropped.
// Reset clears all counters and maximums, sets minimums to 65535 and loads
// the default thresholds and round length; no clearing pass is needed.
module threshold_bin_histogram_minmax_core
  import thbh_pkg::*;
#(
  parameter int BIN_COUNT    = DefBinCount,
  parameter int SAMPLE_SCALE = DefSampleScale
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [SampleW-1:0]  sample_i,
  output logic                empty,
  input  logic                pop,
  output logic [BinIdxW-1:0]  bin_index_o,
  output logic [CountW-1:0]   round_count_o,
  output logic [CountW-1:0]   lowest_count_o,
  output logic [CountW-1:0]   highest_count_o,
  output logic                last_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int BinW = $clog2(BIN_COUNT);

  thr_set_t          thr_q;
  logic [CountW-1:0] spr_q;
  logic              q_pop, q_empty, res_push, res_full;
  logic [BinW-1:0]   q_bin;
  result_t           res_in, res_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumThr; i++) begin
        thr_q[i] <= ThrReset[i];
      end
      spr_q <= SamplesReset;
    end else if (cfg_we_i) begin
      for (int i = 0; i < NumThr; i++) begin
        if (cfg_index_i == CfgIdxW'(i)) begin
          thr_q[i] <= cfg_data_i[ThrW-1:0];
        end
      end
      if (cfg_index_i == CfgIdxSamples) begin
        spr_q <= cfg_data_i;
      end
    end
  end

  thbh_front #(
    .BIN_COUNT    (BIN_COUNT),
    .SAMPLE_SCALE (SAMPLE_SCALE),
    .BinW         (BinW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .sample_i  (sample_i),
    .full_o    (full),
    .thr_i     (thr_q),
    .q_pop_i   (q_pop),
    .q_bin_o   (q_bin),
    .q_empty_o (q_empty)
  );

  thbh_back #(
    .BIN_COUNT (BIN_COUNT),
    .BinW      (BinW)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_empty_i           (q_empty),
    .q_bin_i             (q_bin),
    .q_pop_o             (q_pop),
    .samples_per_round_i (spr_q),
    .res_full_i          (res_full),
    .res_push_o          (res_push),
    .res_o               (res_in)
  );

  // Result queue toward the receiver
  thbh_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (ResQueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign bin_index_o     = res_out.bin_index;
  assign round_count_o   = res_out.round_count;
  assign lowest_count_o  = res_out.lowest_count;
  assign highest_count_o = res_out.highest_count;
  assign last_o          = res_out.last;

endmodule

// ===== sv/thbh_fifo.sv =====
// Small register-based first-in first-out queue.
module thbh_fifo
  import thbh_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/thbh_front.sv =====
// Front end: classifies each sample into a bin and queues the bin number.
module thbh_front
  import thbh_pkg::*;
#(
  parameter int BIN_COUNT    = DefBinCount,
  parameter int SAMPLE_SCALE = DefSampleScale,
  parameter int BinW         = $clog2(BIN_COUNT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [SampleW-1:0] sample_i,
  output logic               full_o,
  input  thr_set_t           thr_i,
  input  logic               q_pop_i,
  output logic [BinW-1:0]    q_bin_o,
  output logic               q_empty_o
);

  logic [BoundW-1:0] bound [BIN_COUNT-1];
  logic [BIN_COUNT-2:0] below;
  logic [BinW-1:0] bin;

  // Exclusive upper bound of each bin but the last
  for (genvar g = 0; g < BIN_COUNT - 1; g++) begin : g_bound
    if (g < NumThr) begin : g_reg
      assign bound[g] = BoundW'(thr_i[g]);
    end else begin : g_scale
      assign bound[g] = BoundW'(SAMPLE_SCALE);
    end
    assign below[g] = (BoundW'(sample_i) < bound[g]);
  end

  // First bin whose bound exceeds the sample, else the last bin
  always_comb begin
    bin = BinW'(BIN_COUNT - 1);
    for (int b = BIN_COUNT - 2; b >= 0; b--) begin
      if (below[b]) begin
        bin = BinW'(b);
      end
    end
  end

  thbh_fifo #(
    .WIDTH (BinW),
    .DEPTH (BinQueueDepth)
  ) u_bin_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (bin),
    .full_o  (full_o),
    .pop_i   (q_pop_i),
    .data_o  (q_bin_o),
    .empty_o (q_empty_o)
  );

endmodule

// ===== sv/thbh_back.sv =====
// Back end: bin counters, round closing and per-bin min/max result sequencing.
module thbh_back
  import thbh_pkg::*;
#(
  parameter int BIN_COUNT = DefBinCount,
  parameter int BinW      = $clog2(BIN_COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  logic [BinW-1:0]   q_bin_i,
  output logic              q_pop_o,
  input  logic [CountW-1:0] samples_per_round_i,
  input  logic              res_full_i,
  output logic              res_push_o,
  output result_t           res_o
);

  back_state_e       state_q, state_d;
  logic [BinW-1:0]   idx_q, idx_d;
  logic [CountW-1:0] smp_q, smp_d;
  logic [CountW-1:0] cnt_q [BIN_COUNT];
  logic [CountW-1:0] cnt_d [BIN_COUNT];
  logic [CountW-1:0] min_q [BIN_COUNT];
  logic [CountW-1:0] min_d [BIN_COUNT];
  logic [CountW-1:0] max_q [BIN_COUNT];
  logic [CountW-1:0] max_d [BIN_COUNT];

  logic [CountW-1:0] sel_cnt, new_min, new_max, smp_inc, limit;
  logic [4:0]        idx_ext;

  // Drain read of the bin being reported
  assign sel_cnt = cnt_q[idx_q];
  assign new_min = (sel_cnt < min_q[idx_q]) ? sel_cnt : min_q[idx_q];
  assign new_max = (sel_cnt > max_q[idx_q]) ? sel_cnt : max_q[idx_q];
  assign idx_ext = 5'(idx_q) + 5'd1;

  assign smp_inc = (smp_q == CountMax) ? smp_q : smp_q + 16'd1;
  assign limit   = (samples_per_round_i == '0) ? 16'd1 : samples_per_round_i;

  assign q_pop_o    = (state_q == ST_RUN) && !q_empty_i;
  assign res_push_o = (state_q == ST_DRAIN) && !res_full_i;

  // Result payload
  always_comb begin
    res_o.bin_index     = idx_ext[BinIdxW-1:0];
    res_o.round_count   = sel_cnt;
    res_o.lowest_count  = new_min;
    res_o.highest_count = new_max;
    res_o.last          = (idx_q == BinW'(BIN_COUNT - 1));
  end

  // Counting and round sequencing
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    smp_d   = smp_q;
    cnt_d   = cnt_q;
    min_d   = min_q;
    max_d   = max_q;
    case (state_q)
      ST_RUN: begin
        if (q_pop_o) begin
          // saturating increment of the chosen lane
          for (int b = 0; b < BIN_COUNT; b++) begin
            if (q_bin_i == BinW'(b) && cnt_q[b] != CountMax) begin
              cnt_d[b] = cnt_q[b] + 16'd1;
            end
          end
          if (smp_inc >= limit) begin
            state_d = ST_DRAIN;
            idx_d   = '0;
            smp_d   = '0;
          end else begin
            smp_d = smp_inc;
          end
        end
      end
      ST_DRAIN: begin
        if (res_push_o) begin
          min_d[idx_q] = new_min;
          max_d[idx_q] = new_max;
          cnt_d[idx_q] = '0;
          if (res_o.last) begin
            state_d = ST_RUN;
          end else begin
            idx_d = idx_q + BinW'(1);
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      idx_q   <= '0;
      smp_q   <= '0;
      for (int b = 0; b < BIN_COUNT; b++) begin
        cnt_q[b] <= '0;
        min_q[b] <= CountMax;
        max_q[b] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      smp_q   <= smp_d;
      cnt_q   <= cnt_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

endmodule

// ===== sv/thbh_checker.sv =====
// Port-level checker of the histogram core and its bind.
module thbh_checker
  import thbh_pkg::*;
#(
  parameter int BIN_COUNT = DefBinCount
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [BinIdxW-1:0] bin_index_o,
  input logic [CountW-1:0]  round_count_o,
  input logic [CountW-1:0]  lowest_count_o,
  input logic [CountW-1:0]  highest_count_o,
  input logic               last_o
);

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queues not empty during reset");

  // The final result of a round reports the last bin
  a_last_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |-> (bin_index_o == BinIdxW'(BIN_COUNT)))
    else $error("last flag on wrong bin");

  // A reported count lies between the running minimum and maximum
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (lowest_count_o <= round_count_o) && (round_count_o <= highest_count_o))
    else $error("round count outside min/max");

  // A stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(bin_index_o) && $stable(round_count_o)))
    else $error("stalled result changed");

endmodule

bind threshold_bin_histogram_minmax_core thbh_checker #(
  .BIN_COUNT (BIN_COUNT)
) u_thbh_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for the threshold-bin histogram with running min and max.
module tb;
  import thbh_pkg::*;

  localparam int BinN       = DefBinCount;
  localparam int PipePause  = 10;    // cycles for in-flight samples to settle
  localparam int HoldCycles = 120;   // long receiver stall
  localparam int QuietLimit = 1000;  // watchdog: cycles without any transfer
  localparam int RandPhases = 4;
  localparam int PhaseItems = 26;

  localparam logic [CfgIdxW-1:0] CfgIdxThrOne   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxThrTwo   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxThrThree = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxThrFour  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxThrFive  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi  = 3'd7;

  // Histogram predictor plus the store of pending bin reports
  class histogram_book;
    logic [ThrW-1:0]   bounds [NumThr];
    logic [CountW-1:0] round_len;
    int unsigned       tally [BinN];
    int unsigned       lows [BinN];
    int unsigned       highs [BinN];
    int unsigned       in_round;
    result_t           due_q [$];
    int                errors;
    int                samples_seen;
    int                rounds_closed;
    int                reports_checked;

    function new();
      for (int i = 0; i < NumThr; i++) bounds[i] = ThrReset[i];
      round_len = SamplesReset;
      for (int i = 0; i < BinN; i++) begin
        tally[i] = 0;
        lows[i]  = CountMax;
        highs[i] = 0;
      end
      in_round = 0;
      errors = 0;
      samples_seen = 0;
      rounds_closed = 0;
      reports_checked = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      if (idx < NumThr) bounds[idx] = d[ThrW-1:0];
      else if (idx == CfgIdxSamples) round_len = d;
      // other indexes are ignored
    endfunction

    function int unsigned bound_of(int b);
      if (b < NumThr) return bounds[b];
      return DefSampleScale;
    endfunction

    // One accepted sample: count it and, when the round closes, queue the bin reports
    function void note_sample(logic [SampleW-1:0] s);
      int          b;
      int unsigned lim;
      result_t     r;
      samples_seen++;
      b = 0;
      while (b < BinN - 1 && s >= bound_of(b)) b++;
      if (tally[b] < CountMax) tally[b]++;
      if (in_round < CountMax) in_round++;
      lim = (round_len == 0) ? 1 : round_len;
      if (in_round < lim) return;
      rounds_closed++;
      for (int i = 0; i < BinN; i++) begin
        if (tally[i] < lows[i]) lows[i] = tally[i];
        if (tally[i] > highs[i]) highs[i] = tally[i];
        r.bin_index     = BinIdxW'(i + 1);
        r.round_count   = CountW'(tally[i]);
        r.lowest_count  = CountW'(lows[i]);
        r.highest_count = CountW'(highs[i]);
        r.last          = (i == BinN - 1);
        due_q.push_back(r);
        tally[i] = 0;
      end
      in_round = 0;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        $error("result with nothing pending: bin %0d count %0d",
               got.bin_index, got.round_count);
        errors++;
        return;
      end
      want = due_q.pop_front();
      reports_checked++;
      if (got.bin_index !== want.bin_index) begin
        $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
        errors++;
      end
      if (got.round_count !== want.round_count) begin
        $error("round_count: expected %0d, got %0d", want.round_count, got.round_count);
        errors++;
      end
      if (got.lowest_count !== want.lowest_count) begin
        $error("lowest_count: expected %0d, got %0d", want.lowest_count, got.lowest_count);
        errors++;
      end
      if (got.highest_count !== want.highest_count) begin
        $error("highest_count: expected %0d, got %0d",
               want.highest_count, got.highest_count);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [SampleW-1:0]  sample_i;
  logic                empty;
  logic                pop;
  logic [BinIdxW-1:0]  bin_index_o;
  logic [CountW-1:0]   round_count_o;
  logic [CountW-1:0]   lowest_count_o;
  logic [CountW-1:0]   highest_count_o;
  logic                last_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  histogram_book book = new();
  bit calm_push;      // sender offers back to back
  bit calm_pop;       // receiver pops back to back
  bit hold_pop_req;   // one long receiver stall requested
  int settings_done;
  int quiet_cycles;

  threshold_bin_histogram_minmax_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .sample_i       (sample_i),
    .empty          (empty),
    .pop            (pop),
    .bin_index_o    (bin_index_o),
    .round_count_o  (round_count_o),
    .lowest_count_o (lowest_count_o),
    .highest_count_o(highest_count_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: ends the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sample; returns on the falling edge after its transfer
  task automatic send_sample(input logic [SampleW-1:0] s);
    int gap;
    gap = calm_push ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push     <= 1'b1;
    sample_i <= s;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    book.note_sample(s);
    @(negedge clk_i);
  endtask

  // Leaves cfg_we_i high; the caller lowers it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    book.set_reg(idx, d);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [CfgDataW-1:0] thr [NumThr],
                                input logic [CfgDataW-1:0] round_len);
    write_reg(CfgIdxThrOne, thr[0]);
    write_reg(CfgIdxThrTwo, thr[1]);
    write_reg(CfgIdxThrThree, thr[2]);
    write_reg(CfgIdxThrFour, thr[3]);
    write_reg(CfgIdxThrFive, thr[4]);
    write_reg(CfgIdxSamples, round_len);
    write_reg(CfgIdxSpareLo, CfgDataW'($urandom));
    write_reg(CfgIdxSpareHi, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  // Stop offering, wait for every pending report, then let the pipe settle
  task automatic settle();
    push <= 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
    repeat (PipePause) @(negedge clk_i);
  endtask

  // Receiver: random pops, one long stall on request
  initial begin
    int      gap;
    result_t got;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = calm_pop ? 0 : $urandom_range(0, 18);
      if (hold_pop_req) begin
        hold_pop_req = 1'b0;
        gap += HoldCycles;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      got.bin_index     = bin_index_o;
      got.round_count   = round_count_o;
      got.lowest_count  = lowest_count_o;
      got.highest_count = highest_count_o;
      got.last          = last_o;
      book.check_result(got);
      @(negedge clk_i);
    end
  end

  // Stimulus
  initial begin
    logic [CfgDataW-1:0] thr [NumThr];
    logic [CfgDataW-1:0] round_len;
    logic [SampleW-1:0]  edge_samples [$];
    int                  draws [$];
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    sample_i     = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    calm_push    = 1'b0;
    calm_pop     = 1'b0;
    hold_pop_req = 1'b0;
    settings_done = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset thresholds: both sides of every bound, top of scale, beyond scale
    edge_samples = '{14'd0, 14'd3499, 14'd3500, 14'd6699, 14'd6700, 14'd7999, 14'd8000,
                     14'd8999, 14'd9000, 14'd9549, 14'd9550, 14'd9999, 14'd10000,
                     14'd16383};
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    settle();

    // Round length cut to zero mid-round: treated as one, next sample closes
    write_reg(CfgIdxSamples, 16'd0);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_sample(14'd1);
    send_sample(14'd5000);
    settle();

    // Thresholds out of order, masked high bits, one per round
    thr = '{16'hE328, 16'd100, 16'd0, 16'hFFFF, 16'd10000};
    apply_settings(thr, 16'd1);
    edge_samples = '{14'd50, 14'd9500, 14'd12000, 14'd16383, 14'd0};
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    settle();

    // Longest round, then shortened below the count already taken
    thr = '{16'd3500, 16'd6700, 16'd8000, 16'd9000, 16'd9550};
    apply_settings(thr, 16'hFFFF);
    repeat (4) send_sample(SampleW'($urandom_range(0, 9999)));
    settle();
    write_reg(CfgIdxSamples, 16'd2);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_sample(SampleW'($urandom_range(0, 16383)));
    settle();

    // Random phases with a fresh setting each
    for (int p = 0; p < RandPhases; p++) begin
      draws.delete();
      repeat (NumThr) draws.push_back($urandom_range(0, DefSampleScale));
      case (p)
        0: begin
          draws.sort();
          round_len = CfgDataW'($urandom_range(2, 8));
          calm_push = 1'b0;
          calm_pop  = 1'b0;
        end
        1: begin
          // short rounds, eager sender, stalled receiver: fills the block
          draws.sort();
          round_len    = 16'd1;
          calm_push    = 1'b1;
          calm_pop     = 1'b0;
          hold_pop_req = 1'b1;
        end
        2: begin
          foreach (draws[i]) draws[i] = $urandom_range(0, 16383);
          round_len = 16'd0;
          calm_push = 1'b0;
          calm_pop  = 1'b1;
        end
        default: begin
          foreach (draws[i]) draws[i] = 16383;
          round_len = CfgDataW'($urandom_range(5, 12));
          calm_push = 1'b1;
          calm_pop  = 1'b1;
        end
      endcase
      foreach (thr[i]) thr[i] = CfgDataW'(draws[i]);
      apply_settings(thr, round_len);
      repeat (PhaseItems) begin
        if ($urandom_range(0, 99) < 85) send_sample(SampleW'($urandom_range(0, 9999)));
        else send_sample(SampleW'($urandom_range(0, 16383)));
      end
      settle();
    end

    $display("Covered %0d samples in %0d closed rounds, %0d bin reports checked,",
             book.samples_seen, book.rounds_closed, book.reports_checked);
    $display("across %0d register settings incl. zero and full-scale round lengths.",
             settings_done);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/thbh_pkg.sv
sv/thbh_fifo.sv
sv/thbh_front.sv
sv/thbh_back.sv
sv/threshold_bin_histogram_minmax_core.sv
sv/thbh_checker.sv
test/tb.sv
